/* rtl/mafilt_pkg.sv */
// Shared constants and types for the moving-average filter.
// No dependencies; every other rtl file refers to it by scoped names.
package mafilt_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int WINDOW_RESET = 8;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 22;
   localparam int CNT_W    = 7;
   localparam int PTR_W    = 6;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam int RSP_DATA_W = 24;

   // divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/mafilt_ring.sv */
// Sample ring: single write port, single registered read port.
// Depends on mafilt_pkg for widths and depth.
module mafilt_ring (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [mafilt_pkg::PTR_W-1:0]        wr_addr,
   input  logic [mafilt_pkg::SAMPLE_W-1:0]     wr_data,
   input  logic                                rd_en,
   input  logic [mafilt_pkg::PTR_W-1:0]        rd_addr,
   output logic [mafilt_pkg::SAMPLE_W-1:0]     rd_data
);

   logic [mafilt_pkg::SAMPLE_W-1:0] mem_ff [mafilt_pkg::WINDOW_MAX];
   logic [mafilt_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mafilt_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mafilt_pkg for widths and the status struct.
module mafilt_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mafilt_pkg::SUM_W-1:0]      dividend,
   input  logic [mafilt_pkg::CNT_W-1:0]      divisor,
   output logic [mafilt_pkg::SUM_W-1:0]      quotient,
   output mafilt_pkg::div_stat_type          stat
);

   // dividend shifts out the top while quotient bits shift in at the bottom
   logic [mafilt_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [mafilt_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [mafilt_pkg::CNT_W-1:0]     den_ff, den_in;
   logic [mafilt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic [mafilt_pkg::CNT_W:0] trial;
   logic [mafilt_pkg::CNT_W:0] diff;
   logic                       ge;

   always_comb begin
      trial = {rem_ff, quo_ff[mafilt_pkg::SUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = mafilt_pkg::DIV_CNT_W'(mafilt_pkg::SUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits CNT_W bits
         rem_in = ge ? diff[mafilt_pkg::CNT_W-1:0] : trial[mafilt_pkg::CNT_W-1:0];
         quo_in = {quo_ff[mafilt_pkg::SUM_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/moving_average_filter.sv */
// Top level of the moving-average filter: sequencer, running sum, output register.
// Depends on mafilt_pkg, mafilt_ring and mafilt_div.
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  req_tdata[15:0] sample
//   rsp_      out   rsp_tvalid/rsp_tready  rsp_tdata[15:0] average, [16] window_full
//   csr_      in    csr_valid/csr_ready    csr_data[6:0] window_length
//
// A request steps through the sequencer in order: the ring is read at accept, the
// sum is updated and the bit-serial divider started, the sequencer waits for the
// divider to finish, then the output register is loaded before the next accept.
// Reset is synchronous, active high; window length returns to 8, history clears.
// A waiting result does not block a new request; only the final load stalls
// until the output register is free.
module moving_average_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [15:0] sample
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mafilt_pkg::SAMPLE_W-1:0]      req_tdata,
   // response: [15:0] average, [16] window_full, [23:17] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mafilt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // window length register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mafilt_pkg::CNT_W-1:0]         csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [mafilt_pkg::CNT_W-1:0]    wlen_ff, wlen_in;
   logic [mafilt_pkg::PTR_W-1:0]    ptr_ff, ptr_in;
   logic [mafilt_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic signed [mafilt_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [mafilt_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic                            neg_ff, neg_in;
   logic                            full_ff, full_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mafilt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic csr_write;

   // ring and divider hookup
   logic [mafilt_pkg::SAMPLE_W-1:0] ring_rd_data;
   logic                            ring_wr_en;
   logic                            div_start;
   logic [mafilt_pkg::SUM_W-1:0]    div_dividend;
   logic [mafilt_pkg::SUM_W-1:0]    div_quotient;
   mafilt_pkg::div_stat_type        div_stat;

   // sum update terms
   logic signed [mafilt_pkg::SUM_W-1:0] x_ext;
   logic signed [mafilt_pkg::SUM_W-1:0] old_ext;
   logic signed [mafilt_pkg::SUM_W-1:0] sum_new;
   logic [mafilt_pkg::CNT_W-1:0]    ptr_inc;
   logic [mafilt_pkg::CNT_W-1:0]    cnt_new;
   logic [mafilt_pkg::SAMPLE_W-1:0] avg;
   logic                            rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;

   assign ring_wr_en = (state_ff == ST_SUM);

   mafilt_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (x_ff),
      .rd_en   (req_accept),
      .rd_addr (ptr_ff),
      .rd_data (ring_rd_data)
   );

   mafilt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (cnt_new),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   always_comb begin
      x_ext   = {{(mafilt_pkg::SUM_W - mafilt_pkg::SAMPLE_W){x_ff[mafilt_pkg::SAMPLE_W-1]}},
                 x_ff};
      // the oldest sample leaves only once the window is full
      old_ext = (cnt_ff >= wlen_ff) ?
                {{(mafilt_pkg::SUM_W - mafilt_pkg::SAMPLE_W){ring_rd_data[mafilt_pkg::SAMPLE_W-1]}},
                 ring_rd_data} : '0;
      sum_new = sum_ff - old_ext + x_ext;
      // magnitude is at most WINDOW_MAX * 2^15, which fits unsigned
      div_dividend = sum_new[mafilt_pkg::SUM_W-1] ? (~sum_new + 1'b1) : sum_new;
      ptr_inc = {1'b0, ptr_ff} + 1'b1;
      cnt_new = (cnt_ff < wlen_ff) ? (cnt_ff + 1'b1) : cnt_ff;
      div_start = (state_ff == ST_SUM);

      avg = neg_ff ? (~div_quotient[mafilt_pkg::SAMPLE_W-1:0] + 1'b1)
                   : div_quotient[mafilt_pkg::SAMPLE_W-1:0];
      rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

      state_in     = state_ff;
      wlen_in      = wlen_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      full_in      = full_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in     = req_tdata;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in  = sum_new;
            neg_in  = sum_new[mafilt_pkg::SUM_W-1];
            cnt_in  = cnt_new;
            full_in = (cnt_new >= wlen_ff);
            ptr_in  = (ptr_inc >= wlen_ff) ? '0 : ptr_inc[mafilt_pkg::PTR_W-1:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_data_in  = {{(mafilt_pkg::RSP_DATA_W - mafilt_pkg::SAMPLE_W - 1){1'b0}},
                               full_ff, avg};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register write clears history; zero means one, oversize clamps
      if (csr_write) begin
         if (csr_data == '0) begin
            wlen_in = mafilt_pkg::CNT_W'(1);
         end else if (csr_data > mafilt_pkg::CNT_W'(mafilt_pkg::WINDOW_MAX)) begin
            wlen_in = mafilt_pkg::CNT_W'(mafilt_pkg::WINDOW_MAX);
         end else begin
            wlen_in = csr_data;
         end
         ptr_in = '0;
         cnt_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      neg_ff      <= neg_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= mafilt_pkg::CNT_W'(mafilt_pkg::WINDOW_RESET);
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/mafilt_avg_checker.sv */
`timescale 1ns / 1ps
// Checker for the moving-average filter: watches the request, response and window
// length channels, predicts each average and compares. Depends on mafilt_pkg.
module mafilt_avg_checker
   import mafilt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,    // [15:0] sample
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,    // [15:0] average, [16] window_full
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CNT_W-1:0]       csr_data,     // [6:0] window_length
   output int unsigned            fail_count,
   output int unsigned            outstanding
);

   typedef struct packed {
      logic                window_full;
      logic [SAMPLE_W-1:0] average;
   } avg_result_type;

   avg_result_type expected_avgs[$];

   // predicted filter state
   logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
   logic signed [SUM_W-1:0]    window_sum;
   int unsigned                win_len;
   int unsigned                slot;
   int unsigned                held;

   avg_result_type got, want;

   function automatic int unsigned clamp_window(input logic [CNT_W-1:0] len);
      if (len == 0)
         return 1;
      if (len > WINDOW_MAX)
         return WINDOW_MAX;
      return int'(len);
   endfunction

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic clear_history();
      slot       = 0;
      held       = 0;
      window_sum = '0;
   endtask

   // one sample into the window; queues the average it must produce
   task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
      int unsigned    at;
      int             quotient;
      avg_result_type res;
      at = (slot >= win_len) ? 0 : slot;
      if (held >= win_len)
         window_sum = window_sum - history[at];
      history[at] = s;
      window_sum  = window_sum + s;
      slot = (at + 1 >= win_len) ? 0 : at + 1;
      if (held < win_len)
         held++;
      quotient        = int'(window_sum) / int'(held);   // truncates toward zero
      res.average     = quotient[SAMPLE_W-1:0];
      res.window_full = (held >= win_len);
      expected_avgs.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_avgs.delete();
         foreach (history[i])
            history[i] = '0;
         win_len = WINDOW_RESET;
         clear_history();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.average     = rsp_tdata[SAMPLE_W-1:0];
            got.window_full = rsp_tdata[SAMPLE_W];
            if (expected_avgs.size() == 0) begin
               log_failure($sformatf("unexpected response avg=%0d full=%0b",
                                     $signed(got.average), got.window_full));
            end else begin
               want = expected_avgs.pop_front();
               if (got.average !== want.average || got.window_full !== want.window_full)
                  log_failure($sformatf("avg exp=%0d got=%0d  full exp=%0b got=%0b",
                                        $signed(want.average), $signed(got.average),
                                        want.window_full, got.window_full));
            end
         end
         if (csr_valid && csr_ready) begin
            win_len = clamp_window(csr_data);
            clear_history();
         end
         if (req_tvalid && req_tready)
            take_sample(req_tdata);
      end
      outstanding <= expected_avgs.size();
   end

endmodule

/* tb/moving_average_filter_tb.sv */
`timescale 1ns / 1ps
// Top of the moving-average filter testbench: clock, reset, request and window
// stimulus, verdict. Depends on mafilt_pkg, moving_average_filter, mafilt_avg_checker.
module moving_average_filter_tb;
   import mafilt_pkg::*;

   // wait after the last response before touching the window register
   localparam int SETTLE_CYCLES = 32;
   localparam int DRAIN_CYCLES  = 64;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request: [15:0] sample
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata  = '0;
   // response: [15:0] average, [16] window_full, [23:17] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // window length: [6:0] window_length
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data   = '0;

   int unsigned fail_count;
   int unsigned outstanding;

   // percent of cycles in which each side holds back
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   always #5 clock = ~clock;

   moving_average_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mafilt_avg_checker avg_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // response side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Hand one request to the block. Called right after a rising edge; returns at
   // the edge where it was taken, with valid still high so back-to-back requests
   // need no extra cycle.
   task automatic push_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // The register write clears history, so the block must be idle: every
   // response back, then the latency of one request on top.
   task automatic program_window(input logic [CNT_W-1:0] len);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly full-range noise, with extremes and near-zero values mixed in so the
   // sum reaches its limits and truncation of small negative means shows up
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned roll;
      logic [SAMPLE_W-1:0] v;
      roll = $urandom_range(99);
      if (roll < 12)
         v = 16'h7FFF;
      else if (roll < 24)
         v = 16'h8000;
      else if (roll < 40)
         v = 16'(int'($urandom_range(32)) - 16);
      else
         v = 16'($urandom());
      return v;
   endfunction

   // zero and oversize values exercise the clamping; 64 and 1 are the extremes
   function automatic logic [CNT_W-1:0] pick_window();
      logic [CNT_W-1:0] len;
      case ($urandom_range(11))
         0:       len = '0;
         1, 2:    len = CNT_W'($urandom_range(4, 1));
         3, 4:    len = CNT_W'(WINDOW_MAX);
         5:       len = CNT_W'($urandom_range(127, WINDOW_MAX + 1));
         default: len = CNT_W'($urandom_range(WINDOW_MAX, 1));
      endcase
      return len;
   endfunction

   task automatic run_phase(input int unsigned req_pct, input int unsigned rsp_pct);
      int unsigned sent;
      int unsigned burst;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         program_window(pick_window());
         // 40 to 160 samples, so even a 64-deep window can wrap
         burst = $urandom_range(160, 40);
         repeat (burst) push_sample(pick_sample());
         sent += burst;
      end
   endtask

   initial begin
      int unsigned drain;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default window of 8 straight out of reset. 0,1,-1,-2 gives -2/4, which
      // must truncate to 0, not round down to -1. Then a full window of each
      // extreme so every sample bit toggles and the oldest entry gets replaced.
      push_sample(16'h0000);
      push_sample(16'h0001);
      push_sample(16'hFFFF);
      push_sample(16'hFFFE);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      repeat (8) push_sample(16'h7FFF);
      repeat (8) push_sample(16'h8000);

      // zero length acts as one: each average equals its sample
      program_window('0);
      push_sample(16'h1234);
      push_sample(16'h8001);
      push_sample(16'hFFFF);

      // oversize lengths clamp to the maximum window
      program_window(7'd127);
      repeat (3) push_sample(pick_sample());
      program_window(CNT_W'(WINDOW_MAX + 1));
      repeat (2) push_sample(pick_sample());

      // largest window pinned at both ends: the sum reaches its limits
      program_window(CNT_W'(WINDOW_MAX));
      repeat (WINDOW_MAX + 6) push_sample(16'h7FFF);
      repeat (WINDOW_MAX + 6) push_sample(16'h8000);

      program_window(7'd1);
      repeat (4) push_sample(pick_sample());

      // random part: idle-heavy receiver, idle-heavy sender, then full rate
      run_phase(6, 76);
      run_phase(76, 6);
      run_phase(0, 0);

      req_tvalid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (outstanding != 0 && drain < DRAIN_LIMIT);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
